@@ src/assert_macros.svh @@
// Assertion macros used by the top level of the deque unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

@@ src/lad_pkg.sv @@
// Package with the constants, codes and control types of the deque unit.
package lad_pkg;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	// Marks are held biased by one, so they run from 0 to DEPTH.
	localparam int MARK_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_PUSH_REAR  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_NO_ROOM = 2'd1,
		STAT_EMPTY   = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE   = 1'b0,
		S_FINISH = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic start;
		logic load;
	} ctrl_cmd_t;

endpackage

@@ src/lad_intf.sv @@
// Valid/ready channel interfaces for the request and response beats.
interface lad_in_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        operation;
	logic signed [lad_pkg::DATA_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

interface lad_out_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        status;
	logic signed [lad_pkg::DATA_W-1:0] popped_value;
	logic                              is_empty;
	logic                              is_full;

	modport source (output valid, output status, output popped_value,
		output is_empty, output is_full, input ready);
	modport sink   (input valid, input status, input popped_value,
		input is_empty, input is_full, output ready);
endinterface

@@ src/linear_array_deque_unit.sv @@
// Top level of the linear-array deque unit: controller, datapath and checks.
//
// A deque of lad_pkg::DEPTH 32-bit slots in a non-wrapping array. Each request
// beat pushes or pops at either end and yields exactly one response beat with a
// status, the popped value (zero unless a pop succeeds), and the empty and full
// flags after the step. In the accept cycle the marks move and the slot memory is
// written or read; then, once the output register is free or being taken, the
// registered read data enters the output register. One request is in flight at a
// time, so a new request is not taken until the last one has entered the output
// register. A new request is taken while a response still waits in the output
// register. Slot contents are not cleared at reset; pops only ever read slots
// that an earlier push wrote.
module linear_array_deque_unit (
	input  logic       clk,
	input  logic       arst_n,
	lad_in_if.sink     req,
	lad_out_if.source  rsp
);
	import lad_pkg::*;

	`include "assert_macros.svh"

	ctrl_cmd_t cmd;

	lad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	lad_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.operation    (req.operation),
		.value        (req.value),
		.status       (rsp.status),
		.popped_value (rsp.popped_value),
		.is_empty     (rsp.is_empty),
		.is_full      (rsp.is_full)
	);

	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, req.valid && req.ready, !req.ready)
	`ASSERT_NEXT(a_load_gives_valid, clk, arst_n, cmd.load, rsp.valid)
	`ASSERT_IMPLIES(a_no_start_on_load, clk, arst_n, cmd.load, !cmd.start)
	`ASSERT_IMPLIES(a_full_not_empty, clk, arst_n, rsp.valid && rsp.is_full, !rsp.is_empty)

endmodule

@@ src/lad_ctrl.sv @@
// Controller state machine: sequences one request beat into one response beat.
module lad_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output lad_pkg::ctrl_cmd_t cmd
);
	import lad_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		cmd.start   = 1'b0;
		cmd.load    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.start = req_valid;
				if (req_valid) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				// The result may enter the output register once it is free or being taken.
				cmd.load = !out_valid_q || rsp_ready;
				if (cmd.load) begin
					state_d = S_IDLE;
				end
			end
		endcase
		if (cmd.load) begin
			out_valid_d = 1'b1;
		end else if (rsp_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

@@ src/lad_dp.sv @@
// Datapath: front and rear marks, slot memory and the response register.
module lad_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lad_pkg::ctrl_cmd_t                cmd,
	input  logic [1:0]                        operation,
	input  logic signed [lad_pkg::DATA_W-1:0] value,
	output logic [1:0]                        status,
	output logic signed [lad_pkg::DATA_W-1:0] popped_value,
	output logic                              is_empty,
	output logic                              is_full
);
	import lad_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	// front_q is the front mark plus one, rear_q the rear mark plus one.
	logic [MARK_W-1:0] front_q, rear_q, front_d, rear_d;
	logic [MARK_W-1:0] front_dec, rear_dec;
	status_t           stat_q, stat_d;
	logic              pop_ok_q, pop_ok_d;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [DATA_W-1:0] rdata_q;

	logic [1:0]        out_status_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_empty_q, out_full_q;

	assign front_dec = front_q - MARK_W'(1);
	assign rear_dec  = rear_q - MARK_W'(1);

	always_comb begin
		front_d  = front_q;
		rear_d   = rear_q;
		stat_d   = STAT_DONE;
		pop_ok_d = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = rear_q[ADDR_W-1:0];
		rd_addr  = front_q[ADDR_W-1:0];
		unique case (op_t'(operation))
			OP_PUSH_REAR: begin
				if (rear_q == MARK_W'(DEPTH)) begin
					stat_d = STAT_NO_ROOM;
				end else begin
					wr_en   = 1'b1;
					wr_addr = rear_q[ADDR_W-1:0];
					rear_d  = rear_q + MARK_W'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (front_q == '0) begin
					stat_d = STAT_NO_ROOM;
				end else begin
					wr_en   = 1'b1;
					wr_addr = front_dec[ADDR_W-1:0];
					front_d = front_dec;
				end
			end
			OP_POP_FRONT: begin
				if (front_q == rear_q) begin
					stat_d = STAT_EMPTY;
				end else begin
					pop_ok_d = 1'b1;
					rd_addr  = front_q[ADDR_W-1:0];
					front_d  = front_q + MARK_W'(1);
				end
			end
			OP_POP_REAR: begin
				if (front_q == rear_q) begin
					stat_d = STAT_EMPTY;
				end else begin
					pop_ok_d = 1'b1;
					rd_addr  = rear_dec[ADDR_W-1:0];
					rear_d   = rear_dec;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			rear_q   <= '0;
			stat_q   <= STAT_DONE;
			pop_ok_q <= 1'b0;
		end else if (cmd.start) begin
			front_q  <= front_d;
			rear_q   <= rear_d;
			stat_q   <= stat_d;
			pop_ok_q <= pop_ok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && wr_en) begin
			mem[wr_addr] <= value;
		end
		if (cmd.start) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// The marks have already moved, so the flags reflect the state after the step.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_status_q <= stat_q;
			out_value_q  <= pop_ok_q ? rdata_q : '0;
			out_empty_q  <= (front_q == rear_q);
			out_full_q   <= (front_q == '0) && (rear_q == MARK_W'(DEPTH));
		end
	end

	assign status       = out_status_q;
	assign popped_value = out_value_q;
	assign is_empty     = out_empty_q;
	assign is_full      = out_full_q;

endmodule
